/* rtl/core/htks_pkg.sv */
// htks_pkg: shared types, codes and helpers for the Hamming top-k scan core.
// Used by htks_cell, hamming_topk_scan_core and htks_checker. No dependencies.
package htks_pkg;

    localparam int MAX_CODE_WORDS_DEF  = 32;
    localparam int TOP_DEPTH_DEF       = 1024;
    localparam int DOC_NUMBER_BITS_DEF = 20;

    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 5;
    localparam int RANK_W  = 10;
    localparam int DIST_W  = 12;
    localparam int CW_W    = 6;
    localparam int TOP_W   = 11;
    localparam int CW_RESET  = 18;
    localparam int TOP_RESET = 256;

    typedef enum logic [1:0] {
        FUNC_QUERY = 2'd0,
        FUNC_DOC   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic {
        REG_CODE_WORDS = 1'b0,
        REG_TOP_COUNT  = 1'b1
    } reg_idx_t;

    // read tag travelling down the cell chain
    typedef struct packed {
        logic              active;
        logic [RANK_W-1:0] rank;
    } rd_tag_t;

    function automatic logic [6:0] popcount64(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [6:0]        s;
        a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        s = 7'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 7'(c[i*8 +: 8]);
        end
        return s;
    endfunction

endpackage

/* rtl/core/htks_cell.sv */
// htks_cell: one shortlist slot of the sorted insertion chain, plus one read-bus stage.
// Depends on htks_pkg.
module htks_cell import htks_pkg::*; #(
    parameter int IDX      = 0,
    parameter int KW       = 11,
    parameter int DOC_BITS = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ins_v,
    input  logic [DOC_BITS-1:0] ins_doc,
    input  logic [DIST_W-1:0]   ins_dist,
    input  logic [KW-1:0]       held,
    input  logic [KW-1:0]       top,
    input  logic                prev_g,
    input  logic [DOC_BITS-1:0] prev_doc,
    input  logic [DIST_W-1:0]   prev_dist,
    output logic                g_out,
    output logic                fit_out,
    output logic [DOC_BITS-1:0] doc_out,
    output logic [DIST_W-1:0]   dist_out,
    input  rd_tag_t             rd_in,
    input  logic [DOC_BITS-1:0] rd_doc_in,
    input  logic [DIST_W-1:0]   rd_dist_in,
    output rd_tag_t             rd_out,
    output logic [DOC_BITS-1:0] rd_doc_out,
    output logic [DIST_W-1:0]   rd_dist_out
);

    logic [DOC_BITS-1:0] doc_reg;
    logic [DIST_W-1:0]   dist_reg;
    rd_tag_t             tag_reg;
    logic [DOC_BITS-1:0] rdoc_reg;
    logic [DIST_W-1:0]   rdist_reg;
    logic                slot_valid;
    logic                hit;

    assign slot_valid = KW'(IDX) < held;
    assign g_out      = !slot_valid || (dist_reg > ins_dist);
    assign fit_out    = g_out && (KW'(IDX) < top);
    assign hit        = (32'(rd_in.rank) == 32'(IDX));

    always_ff @(posedge aclk) begin
        if (ins_v && g_out) begin
            doc_reg  <= prev_g ? prev_doc  : ins_doc;
            dist_reg <= prev_g ? prev_dist : ins_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.active <= 1'b0;
        end else begin
            tag_reg.active <= rd_in.active;
        end
        tag_reg.rank <= rd_in.rank;
    end

    always_ff @(posedge aclk) begin
        rdoc_reg     <= hit ? doc_reg  : rd_doc_in;
        rdist_reg    <= hit ? dist_reg : rd_dist_in;
    end

    assign doc_out     = doc_reg;
    assign dist_out    = dist_reg;
    assign rd_out      = tag_reg;
    assign rd_doc_out  = rdoc_reg;
    assign rd_dist_out = rdist_reg;

endmodule

/* rtl/core/hamming_topk_scan_core.sv */
// hamming_topk_scan_core: each document word is registered in stage 1 and added to the
// running distance in stage 2; after the last word the distance is registered and then
// written into the shortlist, one chain cell per slot. A read waits out a held result and
// any document word or insertion still in flight, then walks the read bus through all
// TOP_DEPTH cells to the result register. Synchronous active-low reset clears control,
// counters and config (18 / 256); query and shortlist contents are left unset.
module hamming_topk_scan_core import htks_pkg::*; #(
    parameter int MAX_CODE_WORDS  = MAX_CODE_WORDS_DEF,
    parameter int TOP_DEPTH       = TOP_DEPTH_DEF,
    parameter int DOC_NUMBER_BITS = DOC_NUMBER_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [WIDX_W-1:0]          s_word_index,
    input  logic [WORD_W-1:0]          s_code_word,
    input  logic [RANK_W-1:0]          s_rank,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_entry_valid,
    output logic [DOC_NUMBER_BITS-1:0] m_document_number,
    output logic [DIST_W-1:0]          m_distance
);

    localparam int QW = (MAX_CODE_WORDS > 1) ? $clog2(MAX_CODE_WORDS) : 1;
    localparam int KW = $clog2(TOP_DEPTH + 1);
    localparam logic [DOC_NUMBER_BITS-1:0] DOC_MAX = '1;

    function automatic logic [QW-1:0] qidx(input logic [WIDX_W-1:0] w);
        logic [QW-1:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (w == WIDX_W'(i)) r = QW'(i % MAX_CODE_WORDS);
        end
        return r;
    endfunction

    logic [CW_W-1:0]  cw_reg;
    logic [TOP_W-1:0] top_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg  <= CW_W'(CW_RESET);
            top_reg <= TOP_W'(TOP_RESET);
        end else if (wr_en) begin
            case (reg_idx_t'(paddr[2]))
                REG_CODE_WORDS: cw_reg  <= pwdata[CW_W-1:0];
                REG_TOP_COUNT:  top_reg <= pwdata[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_CODE_WORDS: prdata = 32'(cw_reg);
            REG_TOP_COUNT:  prdata = 32'(top_reg);
            default:        prdata = '0;
        endcase
    end

    logic [7:0]  cw_eff;
    logic [15:0] top_eff16;
    logic [KW-1:0] top_eff;

    always_comb begin
        if (cw_reg == '0) cw_eff = 8'd1;
        else if (8'(cw_reg) > 8'(MAX_CODE_WORDS)) cw_eff = 8'(MAX_CODE_WORDS);
        else cw_eff = 8'(cw_reg);
        if (top_reg == '0) top_eff16 = 16'd1;
        else if (16'(top_reg) > 16'(TOP_DEPTH)) top_eff16 = 16'(TOP_DEPTH);
        else top_eff16 = 16'(top_reg);
    end
    assign top_eff = KW'(top_eff16);

    // stage 1: accept
    logic accept;
    logic is_query, is_doc, is_read, restart;
    logic rd_busy_reg, rd_busy_next;
    logic m_valid_reg;
    logic st_v_reg, st_last_reg;
    logic ins_v_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] q_rd_reg;
    logic [WORD_W-1:0] q_mem [MAX_CODE_WORDS];
    logic [WIDX_W-1:0] pos_reg;
    logic              last_word;

    assign is_query = (func_t'(s_func) == FUNC_QUERY);
    assign is_doc   = (func_t'(s_func) == FUNC_DOC);
    assign is_read  = (func_t'(s_func) == FUNC_READ);
    assign s_ready  = !rd_busy_reg && !(is_read && (m_valid_reg || st_v_reg || ins_v_reg));
    assign accept   = s_valid && s_ready;
    assign restart  = accept && is_query && (s_word_index == '0);
    assign last_word = (8'(pos_reg) + 8'd1) >= cw_eff;

    always_ff @(posedge aclk) begin
        if (accept && is_query) q_mem[qidx(s_word_index)] <= s_code_word;
    end

    always_ff @(posedge aclk) begin
        if (accept && is_doc) begin
            q_rd_reg    <= q_mem[QW'(pos_reg)];
            word_reg    <= s_code_word;
            st_last_reg <= last_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            st_v_reg <= 1'b0;
        end else begin
            st_v_reg <= accept && is_doc;
            if (restart) pos_reg <= '0;
            else if (accept && is_doc) pos_reg <= last_word ? '0 : pos_reg + 1'b1;
        end
    end

    // stage 2: accumulate
    logic [DIST_W-1:0]          run_reg, run_sum;
    logic [DOC_NUMBER_BITS-1:0] doc_cnt_reg;
    logic [DOC_NUMBER_BITS-1:0] ins_doc_reg;
    logic [DIST_W-1:0]          ins_dist_reg;
    logic                       ins_fire;

    assign run_sum  = run_reg + DIST_W'(popcount64(word_reg ^ q_rd_reg));
    assign ins_fire = st_v_reg && st_last_reg && (doc_cnt_reg != DOC_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            doc_cnt_reg <= '0;
            ins_v_reg   <= 1'b0;
        end else begin
            ins_v_reg <= ins_fire && !restart;
            if (restart) begin
                run_reg     <= '0;
                doc_cnt_reg <= '0;
            end else if (st_v_reg) begin
                run_reg <= st_last_reg ? '0 : run_sum;
                if (ins_fire) doc_cnt_reg <= doc_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_fire) begin
            ins_doc_reg  <= doc_cnt_reg;
            ins_dist_reg <= run_sum;
        end
    end

    // stage 3: insertion chain
    logic [KW-1:0] filled_reg, filled_next, held;
    logic [TOP_DEPTH:0]         g_a;
    logic [TOP_DEPTH-1:0]       fit_a;
    logic [DOC_NUMBER_BITS-1:0] doc_a  [TOP_DEPTH+1];
    logic [DIST_W-1:0]          dist_a [TOP_DEPTH+1];
    rd_tag_t                    tag_a  [TOP_DEPTH+1];
    logic [DOC_NUMBER_BITS-1:0] rdoc_a [TOP_DEPTH+1];
    logic [DIST_W-1:0]          rdist_a[TOP_DEPTH+1];

    assign held     = (filled_reg < top_eff) ? filled_reg : top_eff;
    assign g_a[0]   = 1'b0;
    assign doc_a[0] = '0;
    assign dist_a[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TOP_DEPTH; gi++) begin : g_cell
            htks_cell #(.IDX(gi), .KW(KW), .DOC_BITS(DOC_NUMBER_BITS)) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ins_v       (ins_v_reg),
                .ins_doc     (ins_doc_reg),
                .ins_dist    (ins_dist_reg),
                .held        (held),
                .top         (top_eff),
                .prev_g      (g_a[gi]),
                .prev_doc    (doc_a[gi]),
                .prev_dist   (dist_a[gi]),
                .g_out       (g_a[gi+1]),
                .fit_out     (fit_a[gi]),
                .doc_out     (doc_a[gi+1]),
                .dist_out    (dist_a[gi+1]),
                .rd_in       (tag_a[gi]),
                .rd_doc_in   (rdoc_a[gi]),
                .rd_dist_in  (rdist_a[gi]),
                .rd_out      (tag_a[gi+1]),
                .rd_doc_out  (rdoc_a[gi+1]),
                .rd_dist_out (rdist_a[gi+1])
            );
        end
    endgenerate

    always_comb begin
        filled_next = filled_reg;
        if (restart) filled_next = '0;
        else if (ins_v_reg) begin
            if (|fit_a) filled_next = (held < top_eff) ? held + 1'b1 : top_eff;
            else filled_next = held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) filled_reg <= '0;
        else filled_reg <= filled_next;
    end

    // read bus entry and result register
    rd_tag_t                    tag0_reg;
    logic                       m_ev_reg;
    logic [DOC_NUMBER_BITS-1:0] m_doc_reg;
    logic [DIST_W-1:0]          m_dist_reg;
    logic                       rd_hit_valid;

    assign tag_a[0]   = tag0_reg;
    assign rdoc_a[0]  = '0;
    assign rdist_a[0] = '0;
    assign rd_hit_valid = (32'(tag_a[TOP_DEPTH].rank) < 32'(held));

    always_comb begin
        rd_busy_next = rd_busy_reg;
        if (accept && is_read) rd_busy_next = 1'b1;
        else if (tag_a[TOP_DEPTH].active) rd_busy_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg.active <= 1'b0;
            rd_busy_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            tag0_reg.active <= accept && is_read;
            rd_busy_reg     <= rd_busy_next;
            if (tag_a[TOP_DEPTH].active) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
        if (accept) tag0_reg.rank <= s_rank;
    end

    always_ff @(posedge aclk) begin
        if (tag_a[TOP_DEPTH].active) begin
            m_ev_reg   <= rd_hit_valid;
            m_doc_reg  <= rd_hit_valid ? rdoc_a[TOP_DEPTH]  : '0;
            m_dist_reg <= rd_hit_valid ? rdist_a[TOP_DEPTH] : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_entry_valid     = m_ev_reg;
    assign m_document_number = m_doc_reg;
    assign m_distance        = m_dist_reg;

endmodule

/* rtl/core/htks_checker.sv */
// htks_checker: port-level assertions for hamming_topk_scan_core, with its bind.
// Depends on htks_pkg and hamming_topk_scan_core.
module htks_checker import htks_pkg::*; #(
    parameter int DOC_NUMBER_BITS = DOC_NUMBER_BITS_DEF
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [1:0]                 s_func,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_entry_valid,
    input logic [DOC_NUMBER_BITS-1:0] m_document_number,
    input logic [DIST_W-1:0]          m_distance
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_document_number) && $stable(m_distance))
        else $error("stalled result changed");

    a_no_read_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && func_t'(s_func) == FUNC_READ |-> !s_ready)
        else $error("read taken while result pending");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_entry_valid |-> m_document_number == '0 && m_distance == '0)
        else $error("empty rank with nonzero fields");

    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && func_t'(s_func) == FUNC_READ |=> !s_ready)
        else $error("input taken during read walk");

endmodule

bind hamming_topk_scan_core htks_checker #(.DOC_NUMBER_BITS(DOC_NUMBER_BITS)) u_htks_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_func            (s_func),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_entry_valid     (m_entry_valid),
    .m_document_number (m_document_number),
    .m_distance        (m_distance)
);
